FILE: rtl/fft_pkg.sv
// shared types, constants and twiddle table for the radix-2 fft
package fft_pkg;

  localparam int VAL_BITS = 23;
  localparam int GRID_BITS = 6;

  typedef logic signed [VAL_BITS-1:0] val_t;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_RD     = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_WR     = 3'd3;
  localparam logic [2:0] ST_OUT_RD = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;
  localparam logic [2:0] ST_ADD    = 3'd6;

  function automatic logic [23:0] quarter_cos(input logic [4:0] r);
    logic [23:0] v;
    case (r)
      5'd0: v = 24'd8388608;
      5'd1: v = 24'd8348215;
      5'd2: v = 24'd8227423;
      5'd3: v = 24'd8027397;
      5'd4: v = 24'd7750063;
      5'd5: v = 24'd7398092;
      5'd6: v = 24'd6974873;
      5'd7: v = 24'd6484482;
      5'd8: v = 24'd5931642;
      5'd9: v = 24'd5321677;
      5'd10: v = 24'd4660461;
      5'd11: v = 24'd3954362;
      5'd12: v = 24'd3210181;
      5'd13: v = 24'd2435084;
      5'd14: v = 24'd1636536;
      5'd15: v = 24'd822227;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/fft_bfly.sv
// registered complex butterfly: multiply stage then add/subtract stage
module fft_bfly #(
  parameter int TWIDDLE_BITS = 16
) (
  input  logic clk,
  input  logic [5:0] grid,
  input  fft_pkg::val_t a_re,
  input  fft_pkg::val_t a_im,
  input  fft_pkg::val_t b_re,
  input  fft_pkg::val_t b_im,
  output fft_pkg::val_t top_re,
  output fft_pkg::val_t top_im,
  output fft_pkg::val_t bot_re,
  output fft_pkg::val_t bot_im
);

  localparam int PW = fft_pkg::VAL_BITS + TWIDDLE_BITS + 2;
  localparam int SH = 24 - TWIDDLE_BITS;
  localparam logic [TWIDDLE_BITS-1:0] TOP = {1'b0, {(TWIDDLE_BITS-1){1'b1}}};

  function automatic logic signed [TWIDDLE_BITS-1:0] tw_round(input logic [23:0] mag);
    logic [24:0] r;
    begin
      r = ({1'b0, mag} + ((SH > 0) ? (25'd1 << (SH - 1)) : 25'd0)) >> SH;
      if (r > {{(25-TWIDDLE_BITS){1'b0}}, TOP}) r = {{(25-TWIDDLE_BITS){1'b0}}, TOP};
      return $signed(r[TWIDDLE_BITS-1:0]);
    end
  endfunction

  logic [1:0] q;
  logic [4:0] r;
  logic signed [TWIDDLE_BITS-1:0] ta, tb, wc, ws;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  fft_pkg::val_t a_re_d, a_im_d, vr, vi;
  logic signed [PW-1:0] sr, si;

  assign q = grid[5:4];
  assign r = {1'b0, grid[3:0]};
  assign ta = tw_round(fft_pkg::quarter_cos(r));
  assign tb = tw_round(fft_pkg::quarter_cos(5'd16 - r));

  always_comb begin
    case (q)
      2'd0: begin wc = ta; ws = tb; end
      2'd1: begin wc = -tb; ws = ta; end
      2'd2: begin wc = -ta; ws = -tb; end
      default: begin wc = tb; ws = -ta; end
    endcase
  end

  always_ff @(posedge clk) begin
    p_rr <= PW'(b_re * wc);
    p_ii <= PW'(b_im * ws);
    p_ri <= PW'(b_re * ws);
    p_ir <= PW'(b_im * wc);
    a_re_d <= a_re;
    a_im_d <= a_im;
  end

  assign sr = p_rr - p_ii + (PW'(1) <<< (TWIDDLE_BITS - 2));
  assign si = p_ri + p_ir + (PW'(1) <<< (TWIDDLE_BITS - 2));
  assign vr = fft_pkg::val_t'(sr >>> (TWIDDLE_BITS - 1));
  assign vi = fft_pkg::val_t'(si >>> (TWIDDLE_BITS - 1));

  always_ff @(posedge clk) begin
    top_re <= a_re_d + vr;
    top_im <= a_im_d + vi;
    bot_re <= a_re_d - vr;
    bot_im <= a_im_d - vi;
  end

endmodule

FILE: rtl/fft_radix2_dit.sv
// radix-2 decimation-in-time fft top level with load, compute and unload sequencer
// load: one sample per cycle, none while cfg_we; bit-reversed write, 64-entry work memory
// compute: (N/2)*log2(N) butterflies, each read, multiply, add, write via one shared unit
// unload: N bins, each a memory read, output register and handshake
// a stall on the output extends unload
// synchronous reset clears control state and sets log2_points to 6; the memory is not cleared
module fft_radix2_dit #(
  parameter int MAX_POINTS = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  output logic out_valid,
  input  logic out_stall,
  output fft_pkg::val_t bin_re,
  output fft_pkg::val_t bin_im,
  output logic [5:0] bin_index,
  output logic final_bin
);

  localparam logic [2:0] MAXL = (MAX_POINTS >= 64) ? 3'd6 : (MAX_POINTS >= 32) ? 3'd5 :
                                (MAX_POINTS >= 16) ? 3'd4 : (MAX_POINTS >= 8) ? 3'd3 :
                                (MAX_POINTS >= 4) ? 3'd2 : 3'd1;

  logic [2:0] log2_points, l;
  logic [2:0] state;
  logic [6:0] load_count;
  logic [6:0] n;
  logic [2:0] stage;
  logic [5:0] k, j;
  logic [6:0] span;
  logic [5:0] h, t, u, pos;
  logic [5:0] grid;

  logic [45:0] mem [64];
  logic [45:0] rd_a, rd_b;
  logic [5:0] ra, rb;
  logic [5:0] wa;
  logic [45:0] wd;
  logic we;
  logic [5:0] wa2;
  logic [45:0] wd2;
  logic we2;
  fft_pkg::val_t top_re, top_im, bot_re, bot_im;
  logic [6:0] oidx;

  assign l = (log2_points == 3'd0) ? 3'd1 : (log2_points > MAXL) ? MAXL : log2_points;
  assign n = 7'd1 << l;
  assign span = 7'd2 << stage;
  assign h = 6'(span >> 1);
  assign t = j + k;
  assign u = t + h;
  assign grid = 6'((k * (7'd64 >> (stage + 3'd1))) & 6'h3f);

  always_comb begin
    pos = '0;
    for (int i = 0; i < 6; i++) begin
      if (i < l) pos[l - 3'd1 - 3'(i)] = load_count[i];
    end
  end

  assign in_stall = (state != fft_pkg::ST_LOAD);

  always_comb begin
    ra = t;
    rb = u;
    if (state == fft_pkg::ST_OUT_RD) ra = oidx[5:0];
    we = 1'b0;
    wa = pos;
    wd = {fft_pkg::val_t'(sample_re), fft_pkg::val_t'(sample_im)};
    we2 = 1'b0;
    wa2 = u;
    wd2 = {bot_re, bot_im};
    if (state == fft_pkg::ST_LOAD && in_valid) we = 1'b1;
    if (state == fft_pkg::ST_WR) begin
      we = 1'b1;
      wa = t;
      wd = {top_re, top_im};
      we2 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (we2) mem[wa2] <= wd2;
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
    .clk(clk), .grid(grid),
    .a_re(rd_a[45:23]), .a_im(rd_a[22:0]),
    .b_re(rd_b[45:23]), .b_im(rd_b[22:0]),
    .top_re(top_re), .top_im(top_im), .bot_re(bot_re), .bot_im(bot_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fft_pkg::ST_LOAD;
      log2_points <= 3'd6;
      load_count <= '0;
      out_valid <= 1'b0;
      stage <= '0;
      k <= '0;
      j <= '0;
      oidx <= '0;
    end else begin
      if (cfg_we) begin
        log2_points <= cfg_wdata;
        load_count <= '0;
      end
      case (state)
        fft_pkg::ST_LOAD: begin
          if (in_valid && !cfg_we) begin
            if (load_count + 7'd1 >= n) begin
              load_count <= '0;
              state <= fft_pkg::ST_RD;
              stage <= '0;
              k <= '0;
              j <= '0;
            end else begin
              load_count <= load_count + 7'd1;
            end
          end
        end
        fft_pkg::ST_RD: state <= fft_pkg::ST_MUL;
        fft_pkg::ST_MUL: state <= fft_pkg::ST_ADD;
        fft_pkg::ST_ADD: state <= fft_pkg::ST_WR;
        fft_pkg::ST_WR: begin
          state <= fft_pkg::ST_RD;
          if ({1'b0, j} + span >= n) begin
            j <= '0;
            if (k + 6'd1 >= h) begin
              k <= '0;
              if (stage + 3'd1 >= l) begin
                state <= fft_pkg::ST_OUT_RD;
                oidx <= '0;
              end else begin
                stage <= stage + 3'd1;
              end
            end else begin
              k <= k + 6'd1;
            end
          end else begin
            j <= 6'(j + span);
          end
        end
        fft_pkg::ST_OUT_RD: state <= fft_pkg::ST_OUT;
        fft_pkg::ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            bin_re <= rd_a[45:23];
            bin_im <= rd_a[22:0];
            bin_index <= oidx[5:0];
            final_bin <= (oidx + 7'd1 == n);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (oidx + 7'd1 == n) begin
              state <= fft_pkg::ST_LOAD;
            end else begin
              oidx <= oidx + 7'd1;
              state <= fft_pkg::ST_OUT_RD;
            end
          end
        end
        default: state <= fft_pkg::ST_LOAD;
      endcase
    end
  end

  a_load_only: assert property (@(posedge clk) disable iff (rst)
    (state != fft_pkg::ST_LOAD) |-> in_stall) else $error("accepting while busy");
  a_out_in_unload: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == fft_pkg::ST_OUT)) else $error("bin outside unload");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    load_count < n || load_count == 7'd0 || $past(cfg_we)) else $error("load count overrun");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == fft_pkg::ST_OUT) |-> (oidx < n)) else $error("bin index overrun");

endmodule
